// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/dmc_pkg.sv =====
package dmc_pkg;

    localparam int NUM_LINES    = 8;
    localparam int BLOCK_WORDS  = 4;
    localparam int MEMORY_WORDS = 1024;

    localparam int ADDR_W   = 10;
    localparam int DATA_W   = 32;
    localparam int OFF_W    = $clog2(BLOCK_WORDS);
    localparam int IDX_W    = $clog2(NUM_LINES);
    localparam int TAG_W    = ADDR_W - OFF_W - IDX_W;
    localparam int MEM_AW   = $clog2(MEMORY_WORDS);
    localparam int LINE_AW  = IDX_W + OFF_W;
    localparam int STEP_W   = $clog2(BLOCK_WORDS + 1);
    localparam int LAT_W    = 4;
    localparam int CYC_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [LAT_W-1:0] LATENCY_RESET = LAT_W'(4);
    localparam logic [CYC_W-1:0] BASE_CYCLES   = CYC_W'(3);

    localparam logic POLICY_WB = 1'b0;
    localparam logic POLICY_WT = 1'b1;
    localparam logic OP_READ   = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLICY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LATENCY = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FLUSH,
        ST_REFILL,
        ST_ACCESS,
        ST_RESPOND
    } t_state;

    typedef struct packed {
        logic clr_wr;       // zero one backing word, advance clear address
        logic capture;      // latch request
        logic lookup;       // record hit, read line word at request slot
        logic line_wr_slot; // write request word into line
        logic set_dirty;
        logic mem_wr_word;  // write request word into backing memory
        logic flush_step;
        logic flush_end;
        logic refill_step;
        logic refill_end;
        logic rd_slot;      // read line word at request slot
        logic step_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic is_write;
        logic policy_wt;
        logic hit;
        logic victim_dirty;
        logic step_done;
        logic clear_done;
    } t_dp_sts;

endpackage

// ===== design/direct_mapped_cache_controller_core.sv =====
// Direct-mapped cache (8 lines of 4 words) in front of a 1024-word backing
// memory held inside the block. After reset the backing memory is zeroed one
// word per cycle, so busy stays high until every word is cleared; configuration
// writes are taken at any time (o_cfg_ready is always high). A request is taken
// when start is high and busy is low, and its result appears on the o_ ports
// with o_done high for exactly one cycle; the receiver cannot stall, so the
// result must be taken then. A hit and a write-through write miss go from
// lookup straight to respond; a clean miss refills the line and then accesses
// it; a dirty victim goes back before the refill. busy drops in the cycle after
// o_done. The miss paths follow from the memories having one read and one write
// port each: a block moves one word per cycle, and the read pipeline is drained
// at the end of both writeback and refill.
module direct_mapped_cache_controller_core
    import dmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  o_done,
    output logic [DATA_W-1:0]     o_read_data,
    output logic                  o_cache_hit,
    output logic                  o_mem_read,
    output logic                  o_mem_write,
    output logic [CYC_W-1:0]      o_cycles_taken,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_write_policy;
    logic [LAT_W-1:0] r_memory_latency;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_policy   <= POLICY_WB;
            r_memory_latency <= LATENCY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_POLICY:  r_write_policy   <= i_cfg_data[0];
                CFG_IDX_LATENCY: r_memory_latency <= i_cfg_data[LAT_W-1:0];
                default:         r_write_policy   <= r_write_policy;
            endcase
        end
    end

    dmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dmc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_write_policy   (r_write_policy),
        .i_memory_latency (r_memory_latency),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .o_read_data      (o_read_data),
        .o_cache_hit      (o_cache_hit),
        .o_mem_read       (o_mem_read),
        .o_mem_write      (o_mem_write),
        .o_cycles_taken   (o_cycles_taken)
    );

endmodule

// ===== design/dmc_ctrl.sv =====
module dmc_ctrl
    import dmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (i_sts.hit || (i_sts.is_write && i_sts.policy_wt)) begin
                    n_state = ST_RESPOND;
                end else if (i_sts.victim_dirty) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_REFILL;
                end
            end
            ST_FLUSH: begin
                if (i_sts.step_done) n_state = ST_REFILL;
            end
            ST_REFILL: begin
                if (i_sts.step_done) n_state = ST_ACCESS;
            end
            ST_ACCESS:  n_state = ST_RESPOND;
            ST_RESPOND: n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_LOOKUP: begin
                o_cmd.lookup   = 1'b1;
                o_cmd.step_clr = 1'b1;
                if (i_sts.is_write) begin
                    if (i_sts.hit) begin
                        o_cmd.line_wr_slot = 1'b1;
                        if (i_sts.policy_wt) begin
                            o_cmd.mem_wr_word = 1'b1;
                        end else begin
                            o_cmd.set_dirty = 1'b1;
                        end
                    end else if (i_sts.policy_wt) begin
                        o_cmd.mem_wr_word = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush_step = 1'b1;
                if (i_sts.step_done) begin
                    o_cmd.flush_end = 1'b1;
                    o_cmd.step_clr  = 1'b1;
                end
            end
            ST_REFILL: begin
                o_cmd.refill_step = 1'b1;
                o_cmd.refill_end  = i_sts.step_done;
            end
            ST_ACCESS: begin
                if (i_sts.is_write) begin
                    o_cmd.line_wr_slot = 1'b1;
                    o_cmd.set_dirty    = 1'b1;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                end
            end
            ST_RESPOND: begin
                o_done = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/dmc_dp.sv =====
`include "assert_macros.svh"

module dmc_dp
    import dmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_write_policy,
    input  logic [LAT_W-1:0]  i_memory_latency,
    input  logic              i_operation,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_cache_hit,
    output logic              o_mem_read,
    output logic              o_mem_write,
    output logic [CYC_W-1:0]  o_cycles_taken
);

    // Request
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;

    // Line state
    logic [NUM_LINES-1:0] r_valid;
    logic [NUM_LINES-1:0] r_dirty;
    logic [TAG_W-1:0]     r_tag [NUM_LINES];

    // Storage
    logic [DATA_W-1:0] r_line_mem [NUM_LINES*BLOCK_WORDS];
    logic [DATA_W-1:0] r_line_rdata;
    logic [DATA_W-1:0] r_back_mem [MEMORY_WORDS];
    logic [DATA_W-1:0] r_back_rdata;

    // Sequencing
    logic [MEM_AW-1:0] r_clr_addr;
    logic [STEP_W-1:0] r_step;

    // Result
    logic             r_hit;
    logic             r_mrd;
    logic             r_mwr;
    logic [CYC_W-1:0] r_cycles;
    logic [CYC_W-1:0] n_cycles;

    logic [OFF_W-1:0] req_off;
    logic [IDX_W-1:0] req_idx;
    logic [TAG_W-1:0] req_tag;
    logic [OFF_W-1:0] step_lo;
    logic [OFF_W-1:0] step_prev;
    logic             step_first;
    logic             step_done;
    logic             hit;

    logic               line_we;
    logic [LINE_AW-1:0] line_waddr;
    logic [DATA_W-1:0]  line_wdata;
    logic               line_re;
    logic [LINE_AW-1:0] line_raddr;
    logic               back_we;
    logic [MEM_AW-1:0]  back_waddr;
    logic [DATA_W-1:0]  back_wdata;
    logic               back_re;
    logic [MEM_AW-1:0]  back_raddr;

    assign req_off = r_addr[OFF_W-1:0];
    assign req_idx = r_addr[OFF_W +: IDX_W];
    assign req_tag = r_addr[ADDR_W-1 -: TAG_W];

    assign step_lo    = r_step[OFF_W-1:0];
    assign step_prev  = OFF_W'(r_step - STEP_W'(1));
    assign step_first = (r_step == '0);
    assign step_done  = (r_step == STEP_W'(BLOCK_WORDS));

    assign hit = r_valid[req_idx] && (r_tag[req_idx] == req_tag);

    assign o_sts.is_write     = (r_op == OP_WRITE);
    assign o_sts.policy_wt    = (i_write_policy == POLICY_WT);
    assign o_sts.hit          = hit;
    assign o_sts.victim_dirty = r_valid[req_idx] && r_dirty[req_idx];
    assign o_sts.step_done    = step_done;
    assign o_sts.clear_done   = (r_clr_addr == MEM_AW'(MEMORY_WORDS - 1));

    // Line memory port selection
    always_comb begin
        line_we    = 1'b0;
        line_waddr = {req_idx, req_off};
        line_wdata = r_wdata;
        if (i_cmd.line_wr_slot) begin
            line_we = 1'b1;
        end else if (i_cmd.refill_step && !step_first) begin
            line_we    = 1'b1;
            line_waddr = {req_idx, step_prev};
            line_wdata = r_back_rdata;
        end
        line_re    = i_cmd.lookup || i_cmd.rd_slot;
        line_raddr = {req_idx, req_off};
        if (i_cmd.flush_step) begin
            line_re    = !step_done;
            line_raddr = {req_idx, step_lo};
        end
    end

    // Backing memory port selection
    always_comb begin
        back_we    = 1'b0;
        back_waddr = r_addr[MEM_AW-1:0];
        back_wdata = r_wdata;
        if (i_cmd.clr_wr) begin
            back_we    = 1'b1;
            back_waddr = r_clr_addr;
            back_wdata = '0;
        end else if (i_cmd.mem_wr_word) begin
            back_we = 1'b1;
        end else if (i_cmd.flush_step && !step_first) begin
            // victim block goes back at its own tag
            back_we    = 1'b1;
            back_waddr = MEM_AW'({r_tag[req_idx], req_idx, step_prev});
            back_wdata = r_line_rdata;
        end
        back_re    = i_cmd.refill_step && !step_done;
        back_raddr = MEM_AW'({req_tag, req_idx, step_lo});
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[line_waddr] <= line_wdata;
        end
        if (line_re) begin
            r_line_rdata <= r_line_mem[line_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_we) begin
            r_back_mem[back_waddr] <= back_wdata;
        end
        if (back_re) begin
            r_back_rdata <= r_back_mem[back_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_dirty    <= '0;
            r_clr_addr <= '0;
            r_step     <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
            end
            if (i_cmd.step_clr || i_cmd.refill_end) begin
                r_step <= '0;
            end else if (i_cmd.flush_step || i_cmd.refill_step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.set_dirty) begin
                r_dirty[req_idx] <= 1'b1;
            end else if (i_cmd.flush_end || i_cmd.refill_end) begin
                r_dirty[req_idx] <= 1'b0;
            end
            if (i_cmd.refill_end) begin
                r_valid[req_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.refill_end) begin
            r_tag[req_idx] <= req_tag;
        end
    end

    always_comb begin
        n_cycles = r_cycles;
        if (i_cmd.mem_wr_word || i_cmd.flush_end) begin
            n_cycles = r_cycles + CYC_W'(i_memory_latency);
        end else if (i_cmd.refill_end) begin
            n_cycles = r_cycles + CYC_W'(i_memory_latency) + CYC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_addr   <= i_address;
            r_wdata  <= i_write_data;
            r_hit    <= 1'b0;
            r_mrd    <= 1'b0;
            r_mwr    <= 1'b0;
            r_cycles <= BASE_CYCLES;
        end else begin
            r_cycles <= n_cycles;
            if (i_cmd.lookup) begin
                r_hit <= hit;
            end
            if (i_cmd.refill_end) begin
                r_mrd <= 1'b1;
            end
            if (i_cmd.mem_wr_word || i_cmd.flush_end) begin
                r_mwr <= 1'b1;
            end
        end
    end

    assign o_read_data    = (r_op == OP_WRITE) ? '0 : r_line_rdata;
    assign o_cache_hit    = r_hit;
    assign o_mem_read     = r_mrd;
    assign o_mem_write    = r_mwr;
    assign o_cycles_taken = r_cycles;

    `AST_IMPLY(a_flush_dirty_only, i_clk, i_rst_n, i_cmd.flush_step, r_valid[req_idx] && r_dirty[req_idx])
    `AST_NEXT(a_refill_installs, i_clk, i_rst_n, i_cmd.refill_end, r_valid[req_idx] && !r_dirty[req_idx] && (r_tag[req_idx] == req_tag))
    `AST_NEXT(a_capture_clears, i_clk, i_rst_n, i_cmd.capture, (r_cycles == BASE_CYCLES) && !r_mrd && !r_mwr && !r_hit)
    `AST_IMPLY(a_hit_no_transfer, i_clk, i_rst_n, i_cmd.lookup && hit, !i_cmd.flush_step && !i_cmd.refill_step)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dmc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int unsigned       gap;
    } t_cache_req;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              hit;
        logic              mem_rd;
        logic              mem_wr;
        logic [CYC_W-1:0]  cycles;
    } t_cache_rsp;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  i_operation  = OP_READ;
    logic [ADDR_W-1:0]     i_address    = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic                  o_done;
    logic [DATA_W-1:0]     o_read_data;
    logic                  o_cache_hit;
    logic                  o_mem_read;
    logic                  o_mem_write;
    logic [CYC_W-1:0]      o_cycles_taken;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_IDX_POLICY;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    direct_mapped_cache_controller_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_cache_hit    (o_cache_hit),
        .o_mem_read     (o_mem_read),
        .o_mem_write    (o_mem_write),
        .o_cycles_taken (o_cycles_taken),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // cache and memory image kept alongside the block
    logic              policy  = POLICY_WB;
    logic [LAT_W-1:0]  mem_lat = LATENCY_RESET;
    logic              ln_valid  [NUM_LINES];
    logic              ln_dirty  [NUM_LINES];
    logic [TAG_W-1:0]  ln_tag    [NUM_LINES];
    logic [DATA_W-1:0] ln_word   [NUM_LINES*BLOCK_WORDS];
    logic [DATA_W-1:0] mem_image [MEMORY_WORDS];

    t_cache_req  request_q[$];
    t_cache_rsp  expected_rsp_q[$];
    int unsigned gap_left   = 0;
    t_cache_req  parked_req;
    int          idle_pct   = 0;
    int          mismatches = 0;
    int          req_count  = 0;
    int          rsp_count  = 0;
    int          hit_count  = 0;
    int          refills    = 0;
    int          writebacks = 0;
    int          cfg_writes = 0;
    int          cycle_count;

    function automatic void model_cache_access(input logic op, input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wdata);
        logic [TAG_W-1:0]   tag;
        logic [IDX_W-1:0]   idx;
        logic [OFF_W-1:0]   off;
        logic [LINE_AW-1:0] slot;
        t_cache_rsp         rsp;
        {tag, idx, off} = addr;
        slot = {idx, off};
        rsp = '0;
        rsp.cycles = BASE_CYCLES;
        rsp.hit = ln_valid[idx] && (ln_tag[idx] == tag);
        if (rsp.hit) begin
            hit_count++;
            if (op == OP_READ) begin
                rsp.rdata = ln_word[slot];
            end else begin
                ln_word[slot] = wdata;
                if (policy == POLICY_WB) begin
                    ln_dirty[idx] = 1'b1;
                end else begin
                    mem_image[addr] = wdata;
                    rsp.mem_wr = 1'b1;
                    rsp.cycles += CYC_W'(mem_lat);
                end
            end
        end else if (policy == POLICY_WT && op == OP_WRITE) begin
            // no allocation: the word goes straight to memory
            mem_image[addr] = wdata;
            rsp.mem_wr = 1'b1;
            rsp.cycles += CYC_W'(mem_lat);
        end else begin
            // dirty victim goes back first, whatever the current policy
            if (ln_valid[idx] && ln_dirty[idx]) begin
                for (int i = 0; i < BLOCK_WORDS; i++)
                    mem_image[{ln_tag[idx], idx, OFF_W'(i)}] = ln_word[{idx, OFF_W'(i)}];
                rsp.mem_wr = 1'b1;
                rsp.cycles += CYC_W'(mem_lat);
                writebacks++;
            end
            for (int i = 0; i < BLOCK_WORDS; i++)
                ln_word[{idx, OFF_W'(i)}] = mem_image[{tag, idx, OFF_W'(i)}];
            ln_valid[idx] = 1'b1;
            ln_tag[idx]   = tag;
            ln_dirty[idx] = 1'b0;
            rsp.mem_rd = 1'b1;
            rsp.cycles += CYC_W'(mem_lat) + CYC_W'(1);
            refills++;
            if (op == OP_WRITE) begin
                ln_word[slot] = wdata;
                ln_dirty[idx] = 1'b1;
            end else begin
                rsp.rdata = ln_word[slot];
            end
        end
        expected_rsp_q.push_back(rsp);
    endfunction

    function automatic void push_req(input logic op, input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] data);
        t_cache_req r;
        r.op   = op;
        r.addr = addr;
        r.data = data;
        r.gap  = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 18) : 0;
        request_q.push_back(r);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive_proc
        t_cache_req nxt;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                model_cache_access(i_operation, i_address, i_write_data);
                req_count++;
            end
            if (start && busy) begin
                // hold the word until busy drops
            end else if (gap_left > 1) begin
                start        <= 1'b0;
                gap_left     <= gap_left - 1;
                i_operation  <= 1'($urandom);
                i_address    <= ADDR_W'($urandom);
                i_write_data <= $urandom;
            end else if (gap_left == 1) begin
                start        <= 1'b1;
                gap_left     <= 0;
                i_operation  <= parked_req.op;
                i_address    <= parked_req.addr;
                i_write_data <= parked_req.data;
            end else if (request_q.size() != 0) begin
                nxt = request_q.pop_front();
                if (nxt.gap != 0) begin
                    parked_req   <= nxt;
                    gap_left     <= nxt.gap;
                    start        <= 1'b0;
                    i_operation  <= 1'($urandom);
                    i_address    <= ADDR_W'($urandom);
                    i_write_data <= $urandom;
                end else begin
                    start        <= 1'b1;
                    i_operation  <= nxt.op;
                    i_address    <= nxt.addr;
                    i_write_data <= nxt.data;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_proc
        t_cache_rsp got;
        t_cache_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            got = {o_read_data, o_cache_hit, o_mem_read, o_mem_write, o_cycles_taken};
            rsp_count++;
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("ERROR %0t: result with nothing pending: data=%h hit=%b rd=%b wr=%b cyc=%0d",
                             $realtime, got.rdata, got.hit, got.mem_rd, got.mem_wr, got.cycles);
            end else begin
                want = expected_rsp_q.pop_front();
                if (got.rdata !== want.rdata || got.hit !== want.hit ||
                    got.mem_rd !== want.mem_rd || got.mem_wr !== want.mem_wr ||
                    got.cycles !== want.cycles) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("ERROR %0t: result %0d", $realtime, rsp_count);
                        $display("  expected data=%h hit=%b rd=%b wr=%b cyc=%0d",
                                 want.rdata, want.hit, want.mem_rd, want.mem_wr, want.cycles);
                        $display("  actual   data=%h hit=%b rd=%b wr=%b cyc=%0d",
                                 got.rdata, got.hit, got.mem_rd, got.mem_wr, got.cycles);
                    end
                end
            end
        end
    end

    initial begin : watchdog_proc
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("ERROR: run stopped after %0d cycles", CYCLE_LIMIT);
        $display("direct_mapped_cache_controller_core: mismatch");
        $finish;
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || start || gap_left != 0 ||
               expected_rsp_q.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_POLICY)
            policy = val[0];
        else
            mem_lat = val;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic pol, input logic [LAT_W-1:0] lat, input int n,
                             input int pct);
        logic [CFG_DATA_W-1:0] pol_word;
        logic [ADDR_W-1:0]     a;
        logic [DATA_W-1:0]     d;
        wait_drained();
        // upper bits of the policy word are don't-care
        pol_word = CFG_DATA_W'($urandom_range(0, 15));
        pol_word[0] = pol;
        write_reg(CFG_IDX_POLICY, pol_word);
        write_reg(CFG_IDX_LATENCY, CFG_DATA_W'(lat));
        idle_pct = pct;
        @(negedge i_clk);
        for (int k = 0; k < n; k++) begin
            a = ADDR_W'($urandom);
            // crowd most addresses onto a few tags to get hits and conflicts
            if ($urandom_range(0, 9) < 7)
                a[ADDR_W-1 -: TAG_W] = TAG_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom;
            endcase
            push_req(1'($urandom_range(0, 1)), a, d);
        end
    endtask

    initial begin : main_proc
        for (int i = 0; i < NUM_LINES; i++) begin
            ln_valid[i] = 1'b0;
            ln_dirty[i] = 1'b0;
        end
        for (int i = 0; i < MEMORY_WORDS; i++)
            mem_image[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write-back at reset latency: clean and dirty misses, hits
        idle_pct = 30;
        push_req(OP_READ,  ADDR_W'(0),    32'h0000_0000);
        push_req(OP_WRITE, ADDR_W'(0),    32'hFFFF_FFFF);
        push_req(OP_READ,  ADDR_W'(0),    32'h1234_5678);
        push_req(OP_WRITE, ADDR_W'(1023), 32'h0000_0000);
        push_req(OP_WRITE, ADDR_W'(32),   32'hA5A5_A5A5);
        push_req(OP_READ,  ADDR_W'(0),    32'h0000_0000);
        push_req(OP_READ,  ADDR_W'(1020), 32'hFFFF_FFFF);
        push_req(OP_WRITE, ADDR_W'(64),   32'h5A5A_5A5A);

        // switch to write-through with a dirty line still resident
        wait_drained();
        write_reg(CFG_IDX_POLICY, CFG_DATA_W'(POLICY_WT));
        @(negedge i_clk);
        push_req(OP_READ,  ADDR_W'(0),    32'h0000_0000);
        push_req(OP_WRITE, ADDR_W'(1),    32'h1234_5678);
        push_req(OP_WRITE, ADDR_W'(500),  32'hDEAD_BEEF);
        push_req(OP_READ,  ADDR_W'(500),  32'h0000_0000);
        push_req(OP_READ,  ADDR_W'(1),    32'h0000_0000);

        // zero latency
        wait_drained();
        write_reg(CFG_IDX_LATENCY, CFG_DATA_W'(0));
        @(negedge i_clk);
        push_req(OP_WRITE, ADDR_W'(0),    32'h0000_0000);
        push_req(OP_READ,  ADDR_W'(100),  32'h0000_0000);

        // back to write-back at the longest latency
        wait_drained();
        write_reg(CFG_IDX_POLICY, CFG_DATA_W'(POLICY_WB));
        write_reg(CFG_IDX_LATENCY, CFG_DATA_W'(15));
        @(negedge i_clk);
        push_req(OP_WRITE, ADDR_W'(96),   32'h8000_0001);
        push_req(OP_READ,  ADDR_W'(0),    32'h0000_0000);
        push_req(OP_WRITE, ADDR_W'(1023), 32'hFFFF_FFFF);
        push_req(OP_READ,  ADDR_W'(1023), 32'h0000_0000);

        run_phase(POLICY_WT, LAT_W'(1),  110, 30);
        run_phase(POLICY_WB, LAT_W'(15), 110, 0);
        run_phase(POLICY_WT, LAT_W'(0),  110, 40);
        run_phase(POLICY_WB, LAT_W'(7),  110, 25);
        run_phase(POLICY_WT, LAT_W'(15), 100, 20);
        run_phase(POLICY_WB, LAT_W'(1),  100, 35);
        run_phase(1'($urandom_range(0, 1)), LAT_W'($urandom_range(0, 15)), 100, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d hits, %0d block refills, %0d dirty writebacks,",
                 req_count, hit_count, refills, writebacks);
        $display("under %0d register writes across both policies and latencies 0 to 15.",
                 cfg_writes);
        if (mismatches == 0 && expected_rsp_q.size() == 0) begin
            $display("direct_mapped_cache_controller_core: match");
        end else begin
            $display("%0d errors, %0d results never arrived", mismatches, expected_rsp_q.size());
            $display("direct_mapped_cache_controller_core: mismatch");
        end
        $finish;
    end

endmodule
